// ===== src/nmmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmmr_pkg
// Shared widths, decode tables and the output encode function of the
// normal map mip reduction block.
// ----------------------------------------------------------------------------
package nmmr_pkg;

   localparam int CX_W   = 18;   // decoded component, signed Q16 in [-1,1]
   localparam int Z_W    = 17;   // rebuilt z, unsigned Q16 in [0,1]
   localparam int SUM_W  = 20;   // sum of four components, signed
   localparam int SQ_W   = 37;   // square of a sum
   localparam int LEN2_W = 38;   // squared length, Q32
   localparam int LEN_W  = 19;   // length, Q16
   localparam int INV_W  = 33;   // reciprocal length, Q16
   localparam int PROD_W = 54;   // sum times reciprocal

   typedef logic [255:0][CX_W-1:0] dec_tbl_type;
   typedef logic [255:0][Z_W-1:0]  sq_tbl_type;

   // byte -> floor((b*131072 + 127)/255) - 65536
   function automatic dec_tbl_type build_dec_tbl();
      dec_tbl_type t;
      int v;
      for (int i = 0; i < 256; i++) begin
         v = (i * 131072 + 127) / 255 - 65536;
         t[i] = CX_W'(v);
      end
      return t;
   endfunction

   // byte -> square of the decoded component, rounded half up, Q16
   function automatic sq_tbl_type build_sq_tbl();
      sq_tbl_type t;
      longint c;
      for (int i = 0; i < 256; i++) begin
         c = longint'((i * 131072 + 127) / 255 - 65536);
         t[i] = Z_W'((c * c + 32768) >>> 16);
      end
      return t;
   endfunction

   localparam dec_tbl_type DEC_TBL = build_dec_tbl();
   localparam sq_tbl_type  SQ_TBL  = build_sq_tbl();

   // round the Q32 product to Q16, clamp to [-1,1] and map to a byte
   function automatic logic [7:0] encode_q16(input logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W-17:0] n;
      logic signed [PROD_W-16:0] u;
      logic [17:0]               uc;
      logic [25:0]               sc;
      n = (PROD_W-16)'((prod + PROD_W'(32768)) >>> 16);
      u = (PROD_W-15)'(n) + (PROD_W-15)'(65536);
      if (u < 0) begin
         uc = '0;
      end else if (u > (PROD_W-15)'(131072)) begin
         uc = 18'd131072;
      end else begin
         uc = u[17:0];
      end
      sc = 26'(uc) * 26'd255 + 26'd65536;
      return sc[24:17];
   endfunction

endpackage

// ===== src/normal_map_mip_reduce_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normal_map_mip_reduce_core
// Reduces one 2x2 quad of normal/height/cavity texels to one texel of the
// next mip level.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one quad per transfer, texels a, b, c, d packed in req_tdata
//   from the low bits up; each texel holds normal x, normal y, height and
//   cavity bytes from the low byte up.
//   rsp channel: one reduced texel per quad, same order as the requests.
//   Four texel lanes rebuild z in parallel, a merge pipeline sums them,
//   takes the length by a pipelined square root and its reciprocal by a
//   pipelined divider (one quotient bit per stage, 33 stages).
//   Throughput: one quad per cycle while rsp_tready stays high.
//   Stall: when rsp_tready is low with a result waiting, the pipeline still
//   advances while its last stage is empty, then holds; req_tready drops
//   only then.
//   Reset: synchronous; drops every valid flag, no result is pending after.
// ----------------------------------------------------------------------------
module normal_map_mip_reduce_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // texel_a, texel_b, texel_c, texel_d
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata    // normal_x_byte, normal_y_byte, height_byte,
                                     // cavity_byte
);
   logic                             adv, load;
   logic [3:0]                       lane_valid;
   logic [3:0][nmmr_pkg::CX_W-1:0]   lane_cx, lane_cy;
   logic [3:0][nmmr_pkg::Z_W-1:0]    lane_z;
   logic [3:0][7:0]                  lane_h, lane_c;
   logic                             m_valid;
   logic [7:0]                       m_x, m_y, m_h, m_c;
   logic                             rsp_valid_ff;
   logic [31:0]                      rsp_data_ff;

   assign load       = !rsp_valid_ff || rsp_tready;
   assign adv        = load || !m_valid;
   assign req_tready = adv;

   for (genvar i = 0; i < 4; i++) begin : gen_lane
      nmmr_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .in_valid   (req_tvalid),
         .texel      (req_tdata[32*i +: 32]),
         .out_valid  (lane_valid[i]),
         .out_z      (lane_z[i]),
         .out_cx     (lane_cx[i]),
         .out_cy     (lane_cy[i]),
         .out_height (lane_h[i]),
         .out_cavity (lane_c[i])
      );
   end

   nmmr_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (&lane_valid),
      .in_cx      (lane_cx),
      .in_cy      (lane_cy),
      .in_z       (lane_z),
      .in_height  (lane_h),
      .in_cavity  (lane_c),
      .out_valid  (m_valid),
      .out_x      (m_x),
      .out_y      (m_y),
      .out_height (m_h),
      .out_cavity (m_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= m_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && m_valid) begin
         rsp_data_ff <= {m_c, m_h, m_y, m_x};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/nmmr_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmmr_isqrt
// Pipelined integer square root, one root bit per stage, with side data
// carried alongside.
// ----------------------------------------------------------------------------
module nmmr_isqrt #(
   parameter int ROOT_W = 17,
   parameter int SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_rad,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);
   localparam int RAD_W = 2 * ROOT_W;

   logic [RAD_W-1:0]  v_ff    [ROOT_W];
   logic [RAD_W-1:0]  res_ff  [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];
   logic [ROOT_W-1:0] valid_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : gen_stage
      localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ROOT_W - 1 - k));
      logic [RAD_W-1:0]  v_prev, res_prev, trial, v_in, res_in;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;

      if (k == 0) begin : gen_first
         assign v_prev     = in_rad;
         assign res_prev   = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : gen_next
         assign v_prev     = v_ff[k-1];
         assign res_prev   = res_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (v_prev >= trial) begin
            v_in   = v_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            v_in   = v_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            v_ff[k]    <= v_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = res_ff[ROOT_W-1][ROOT_W-1:0];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ===== src/nmmr_recip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmmr_recip
// Pipelined restoring divider for floor(2^32 / len), one quotient bit per
// stage, with side data carried alongside.
// ----------------------------------------------------------------------------
module nmmr_recip #(
   parameter int SIDE_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [nmmr_pkg::LEN_W-1:0] in_len,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output logic [nmmr_pkg::INV_W-1:0] out_inv,
   output logic [SIDE_W-1:0]          out_side
);
   localparam int LW = nmmr_pkg::LEN_W;
   localparam int QW = nmmr_pkg::INV_W;

   logic [LW-1:0]     rem_ff  [QW];
   logic [LW-1:0]     len_ff  [QW];
   logic [QW-1:0]     q_ff    [QW];
   logic [SIDE_W-1:0] side_ff [QW];
   logic [QW-1:0]     valid_ff;

   for (genvar k = 0; k < QW; k++) begin : gen_stage
      logic [LW-1:0]     rem_prev, len_prev, rem_in;
      logic [QW-1:0]     q_prev, q_in;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic [LW:0]       shifted;

      if (k == 0) begin : gen_first
         assign rem_prev   = '0;
         assign len_prev   = in_len;
         assign q_prev     = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : gen_next
         assign rem_prev   = rem_ff[k-1];
         assign len_prev   = len_ff[k-1];
         assign q_prev     = q_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      // the dividend is a single one in its top bit
      always_comb begin
         shifted = {rem_prev, (k == 0) ? 1'b1 : 1'b0};
         if (shifted >= {1'b0, len_prev}) begin
            rem_in = LW'(shifted - {1'b0, len_prev});
            q_in   = {q_prev[QW-2:0], 1'b1};
         end else begin
            rem_in = shifted[LW-1:0];
            q_in   = {q_prev[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            len_ff[k]  <= len_prev;
            q_ff[k]    <= q_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_inv   = q_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

// ===== src/nmmr_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmmr_lane
// One texel lane: decode x and y, rebuild z through a pipelined square root
// and carry the decoded values, height and cavity along.
// ----------------------------------------------------------------------------
module nmmr_lane (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             in_valid,
   input  logic [31:0]                      texel,
   output logic                             out_valid,
   output logic [nmmr_pkg::Z_W-1:0]         out_z,
   output logic signed [nmmr_pkg::CX_W-1:0] out_cx,
   output logic signed [nmmr_pkg::CX_W-1:0] out_cy,
   output logic [7:0]                       out_height,
   output logic [7:0]                       out_cavity
);
   localparam int CW     = nmmr_pkg::CX_W;
   localparam int SIDE_W = 2 * CW + 16;

   logic [CW-1:0]             cx, cy;
   logic [nmmr_pkg::Z_W-1:0]  sqx, sqy;
   logic signed [18:0]        rem;
   logic [2*nmmr_pkg::Z_W-1:0] rad;
   logic [SIDE_W-1:0]         side_out;

   always_comb begin
      cx  = nmmr_pkg::DEC_TBL[texel[7:0]];
      cy  = nmmr_pkg::DEC_TBL[texel[15:8]];
      sqx = nmmr_pkg::SQ_TBL[texel[7:0]];
      sqy = nmmr_pkg::SQ_TBL[texel[15:8]];
      rem = 19'sd65536 - $signed({2'b00, sqx}) - $signed({2'b00, sqy});
      // outside the unit circle: z is zero
      if (rem < 0) begin
         rad = '0;
      end else begin
         rad = {1'b0, rem[16:0], 16'h0000};
      end
   end

   nmmr_isqrt #(
      .ROOT_W (nmmr_pkg::Z_W),
      .SIDE_W (SIDE_W)
   ) u_zroot (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (in_valid),
      .in_rad    (rad),
      .in_side   ({cx, cy, texel[23:16], texel[31:24]}),
      .out_valid (out_valid),
      .out_root  (out_z),
      .out_side  (side_out)
   );

   assign out_cx     = $signed(side_out[SIDE_W-1 -: CW]);
   assign out_cy     = $signed(side_out[SIDE_W-CW-1 -: CW]);
   assign out_height = side_out[15:8];
   assign out_cavity = side_out[7:0];

endmodule

// ===== src/nmmr_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmmr_merge
// Combines the four lanes: sums, squared length, length, reciprocal,
// renormalized products and byte encode; height and cavity ride along.
// ----------------------------------------------------------------------------
module nmmr_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 in_valid,
   input  logic [3:0][nmmr_pkg::CX_W-1:0]       in_cx,
   input  logic [3:0][nmmr_pkg::CX_W-1:0]       in_cy,
   input  logic [3:0][nmmr_pkg::Z_W-1:0]        in_z,
   input  logic [3:0][7:0]                      in_height,
   input  logic [3:0][7:0]                      in_cavity,
   output logic                                 out_valid,
   output logic [7:0]                           out_x,
   output logic [7:0]                           out_y,
   output logic [7:0]                           out_height,
   output logic [7:0]                           out_cavity
);
   localparam int SW     = nmmr_pkg::SUM_W;
   localparam int SIDE_W = 2 * SW + 16;

   // sum stage
   logic signed [SW-1:0] sx_ff, sy_ff, sz_ff, sx_in, sy_in, sz_in;
   logic [7:0]           h_ff, c_ff, h_in, c_in;
   logic                 s0_valid_ff;
   logic [9:0]           hsum, csum;
   logic [7:0]           cmax;
   logic [11:0]          cblend;

   always_comb begin
      sx_in = '0;
      sy_in = '0;
      sz_in = '0;
      hsum  = '0;
      csum  = '0;
      cmax  = '0;
      for (int i = 0; i < 4; i++) begin
         sx_in = sx_in + SW'($signed(in_cx[i]));
         sy_in = sy_in + SW'($signed(in_cy[i]));
         sz_in = sz_in + $signed(SW'(in_z[i]));
         hsum  = hsum + 10'(in_height[i]);
         csum  = csum + 10'(in_cavity[i]);
         if (in_cavity[i] > cmax) begin
            cmax = in_cavity[i];
         end
      end
      h_in   = 8'((hsum + 10'd2) >> 2);
      cblend = 12'(csum) * 12'd3 + {2'b00, cmax, 2'b00} + 12'd8;
      c_in   = cblend[11:4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         sz_ff <= sz_in;
         h_ff  <= h_in;
         c_ff  <= c_in;
      end
   end

   // square stage
   logic [nmmr_pkg::SQ_W-1:0] qx_ff, qy_ff, qz_ff;
   logic signed [SW-1:0]      s1x_ff, s1y_ff;
   logic [7:0]                s1h_ff, s1c_ff;
   logic                      s1_valid_ff;
   logic signed [2*SW-1:0]    px2, py2, pz2;

   assign px2 = sx_ff * sx_ff;
   assign py2 = sy_ff * sy_ff;
   assign pz2 = sz_ff * sz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff  <= px2[nmmr_pkg::SQ_W-1:0];
         qy_ff  <= py2[nmmr_pkg::SQ_W-1:0];
         qz_ff  <= pz2[nmmr_pkg::SQ_W-1:0];
         s1x_ff <= sx_ff;
         s1y_ff <= sy_ff;
         s1h_ff <= h_ff;
         s1c_ff <= c_ff;
      end
   end

   // squared length stage
   logic [nmmr_pkg::LEN2_W-1:0] len2_ff;
   logic [SIDE_W-1:0]           s2side_ff;
   logic                        s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len2_ff   <= nmmr_pkg::LEN2_W'(qx_ff) + nmmr_pkg::LEN2_W'(qy_ff)
                      + nmmr_pkg::LEN2_W'(qz_ff);
         s2side_ff <= {s1x_ff, s1y_ff, s1h_ff, s1c_ff};
      end
   end

   // length and reciprocal
   logic                       len_valid, inv_valid;
   logic [nmmr_pkg::LEN_W-1:0] len;
   logic [SIDE_W-1:0]          len_side;
   logic [nmmr_pkg::INV_W-1:0] inv;
   logic [SIDE_W:0]            inv_side;

   nmmr_isqrt #(
      .ROOT_W (nmmr_pkg::LEN_W),
      .SIDE_W (SIDE_W)
   ) u_len (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s2_valid_ff),
      .in_rad    (len2_ff),
      .in_side   (s2side_ff),
      .out_valid (len_valid),
      .out_root  (len),
      .out_side  (len_side)
   );

   nmmr_recip #(
      .SIDE_W (SIDE_W + 1)
   ) u_recip (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (len_valid),
      .in_len    (len),
      .in_side   ({len == '0, len_side}),
      .out_valid (inv_valid),
      .out_inv   (inv),
      .out_side  (inv_side)
   );

   // product stage
   logic signed [nmmr_pkg::PROD_W-1:0] prx_ff, pry_ff;
   logic                               zero_ff, p_valid_ff;
   logic [7:0]                         ph_ff, pc_ff;
   logic signed [SW-1:0]               rx, ry;
   logic signed [nmmr_pkg::INV_W:0]    inv_s;

   assign rx    = $signed(inv_side[SIDE_W-1 -: SW]);
   assign ry    = $signed(inv_side[SIDE_W-SW-1 -: SW]);
   assign inv_s = $signed({1'b0, inv});

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= inv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prx_ff  <= rx * inv_s;
         pry_ff  <= ry * inv_s;
         zero_ff <= inv_side[SIDE_W];
         ph_ff   <= inv_side[15:8];
         pc_ff   <= inv_side[7:0];
      end
   end

   // a zero-length sum encodes as the flat normal
   assign out_valid  = p_valid_ff;
   assign out_x      = zero_ff ? 8'd128 : nmmr_pkg::encode_q16(prx_ff);
   assign out_y      = zero_ff ? 8'd128 : nmmr_pkg::encode_q16(pry_ff);
   assign out_height = ph_ff;
   assign out_cavity = pc_ff;

endmodule

// ===== src/nmmr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmmr_checker
// Port-level checks of the mip reduce core, bound to the top level.
// ----------------------------------------------------------------------------
module nmmr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   // reset leaves nothing pending
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // a taking receiver always lets the pipeline advance
   assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req_tready low while rsp_tready high");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

endmodule

bind normal_map_mip_reduce_core nmmr_checker u_nmmr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb_normal_map_mip_reduce_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_normal_map_mip_reduce_core
// Self-checking bench for the 2x2 normal map mip reduction core. A directed
// table of quads (extreme bytes, zero-length sums, out-of-unit-circle normals)
// is followed by random quads, with random valid and ready gaps. Each reduced
// texel is compared with a fixed-point model of the reduction.
// ----------------------------------------------------------------------------
module tb_normal_map_mip_reduce_core;

   localparam int N_RANDOM   = 730;
   localparam int WATCHDOG   = 2000;
   localparam int DRAIN_WAIT = 100;
   localparam int MAX_PRINT  = 10;

   typedef struct packed {
      logic [7:0] cavity;
      logic [7:0] height;
      logic [7:0] norm_y;
      logic [7:0] norm_x;
   } texel_type;

   typedef struct {
      logic [127:0] quad;
      logic         typed;   // expected texel typed in below
      logic [31:0]  texel;
   } quad_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;

   logic [31:0]  texel_fifo[$];
   int           mismatches = 0;
   int           checked = 0;
   int           idle_cycles = 0;
   logic         timed_out = 1'b0;
   logic         stimulus_done = 1'b0;
   logic         calm = 1'b0;   // no idling in the last part of the run
   quad_row_type quad_table[$];

   normal_map_mip_reduce_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint to_q16(input logic [7:0] b);
      return (longint'(b) * 131072 + 127) / 255 - 65536;
   endfunction

   function automatic logic [7:0] to_byte(input longint n);
      longint u;
      u = n + 65536;
      if (u < 0) u = 0;
      if (u > 131072) u = 131072;
      return 8'((u * 255 + 65536) / 131072);
   endfunction

   // floor of a Q32 product down to Q16
   function automatic longint q32_floor(input longint p);
      if (p >= 0) return p >>> 16;
      return -((-p + 65535) >>> 16);
   endfunction

   function automatic logic [31:0] reduce_quad(input logic [127:0] quad);
      texel_type       t;
      longint          cx, cy, rem, sx, sy, sz, inv;
      longint unsigned len2, len;
      int              hsum, csum, cmax;
      texel_type       r;
      sx = 0; sy = 0; sz = 0; hsum = 0; csum = 0; cmax = 0;
      for (int i = 0; i < 4; i++) begin
         t = quad[32*i +: 32];
         cx = to_q16(t.norm_x);
         cy = to_q16(t.norm_y);
         rem = 65536 - ((cx * cx + 32768) >>> 16) - ((cy * cy + 32768) >>> 16);
         if (rem < 0) rem = 0;
         sx += cx;
         sy += cy;
         sz += longint'(int_sqrt(longint'(rem) << 16));
         hsum += t.height;
         csum += t.cavity;
         if (t.cavity > cmax) cmax = t.cavity;
      end
      len2 = sx * sx + sy * sy + sz * sz;
      len = int_sqrt(len2);
      if (len == 0) begin
         r.norm_x = 8'd128;
         r.norm_y = 8'd128;
      end else begin
         inv = longint'((64'd1 << 32) / len);
         r.norm_x = to_byte(q32_floor(sx * inv + 32768));
         r.norm_y = to_byte(q32_floor(sy * inv + 32768));
      end
      r.height = 8'((hsum + 2) >> 2);
      r.cavity = 8'((3 * csum + 4 * cmax + 8) >> 4);
      return r;
   endfunction

   function automatic logic [127:0] same_texel(input logic [31:0] t);
      return {t, t, t, t};
   endfunction

   task automatic add_row(input logic [127:0] q, input logic typed, input logic [31:0] e);
      quad_row_type row;
      row.quad = q;
      row.typed = typed;
      row.texel = e;
      quad_table.insert(quad_table.size(), row);
   endtask

   // random quad: mostly raw noise, sometimes in-circle normals
   function automatic logic [127:0] random_quad();
      logic [127:0] q;
      q = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 3) == 0) begin
         for (int i = 0; i < 4; i++) begin
            q[32*i +: 8] = 8'($urandom_range(40, 215));
            q[32*i + 8 +: 8] = 8'($urandom_range(40, 215));
         end
      end
      return q;
   endfunction

   task automatic send_quad(input logic [127:0] q, input logic [31:0] expected);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= q;
      texel_fifo.insert(texel_fifo.size(), expected);
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      logic [127:0] rq;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes: all zero, all ones, centered normal and axis-aligned normals
      add_row('0, 1'b1, 32'h0000_2525);
      add_row('1, 1'b1, 32'hFFFF_DADA);
      add_row(same_texel(32'h8080_8080), 1'b0, '0);
      add_row(same_texel(32'hFF00_0080), 1'b0, '0);
      add_row(same_texel(32'h00FF_8000), 1'b0, '0);
      add_row(same_texel(32'h0000_80FF), 1'b0, '0);
      add_row(same_texel(32'h0000_FF80), 1'b0, '0);
      // opposite corner normals cancel: zero-length sum gives the flat normal
      add_row({32'h0000_FFFF, 32'h0000_0000, 32'h0000_00FF, 32'h0000_FF00}, 1'b1,
              32'h0000_8080);
      add_row({32'h4020_FF00, 32'h4020_00FF, 32'h4020_0000, 32'h4020_FFFF}, 1'b1,
              32'h4020_8080);
      // corners outside the unit circle, z clamps to zero
      add_row(same_texel(32'h1234_FFFF), 1'b0, '0);
      add_row(same_texel(32'h5678_0000), 1'b0, '0);
      add_row({32'h00FF_0000, 32'h0000_00FF, 32'hFF00_FF00, 32'hFF00_0000}, 1'b0, '0);
      // height and cavity rounding, max term
      add_row({32'hFF01_8080, 32'h0002_8080, 32'h0003_8080, 32'h0000_8080}, 1'b0, '0);
      add_row({32'h0180_8080, 32'h02FE_8080, 32'h00FF_8080, 32'h0380_8080}, 1'b0, '0);
      add_row({32'hAA55_AA55, 32'h55AA_55AA, 32'hA5A5_5A5A, 32'h5A5A_A5A5}, 1'b0, '0);

      foreach (quad_table[i]) begin
         if (quad_table[i].typed && reduce_quad(quad_table[i].quad) != quad_table[i].texel)
            $display("table row %0d: typed texel %h disagrees with model %h", i,
                     quad_table[i].texel, reduce_quad(quad_table[i].quad));
         send_quad(quad_table[i].quad, quad_table[i].typed ? quad_table[i].texel
                                                           : reduce_quad(quad_table[i].quad));
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 3) begin
            // hold until the pipeline has drained completely
            req_tvalid <= 1'b0;
            while (texel_fifo.size() != 0) @(posedge clock);
         end
         if (n == N_RANDOM - 120) calm = 1'b1;
         rq = random_quad();
         send_quad(rq, reduce_quad(rq));
      end
      req_tvalid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // result side: random ready bursts, compare on every transfer
   initial begin
      texel_type got, want;
      int        hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready && !reset) begin
            got = rsp_tdata;
            if (texel_fifo.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_PRINT)
                  $display("unexpected texel %h", got);
            end else begin
               want = texel_fifo.pop_front();
               checked++;
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= MAX_PRINT)
                     $display("texel %0d: x %0d/%0d y %0d/%0d h %0d/%0d c %0d/%0d (exp/act)",
                              checked, want.norm_x, got.norm_x, want.norm_y, got.norm_y,
                              want.height, got.height, want.cavity, got.cavity);
               end
            end
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG && !timed_out) timed_out <= 1'b1;
   end

   initial begin
      wait (reset == 1'b0);
      fork
         begin
            wait (stimulus_done && texel_fifo.size() == 0);
            repeat (DRAIN_WAIT) @(posedge clock);
         end
         wait (timed_out);
      join_any
      if (timed_out) begin
         $display("watchdog expired, %0d texels still expected", texel_fifo.size());
         $display("Some tests failed");
      end else begin
         $display("checked %0d reduced texels: directed extremes, cancelling normals,", checked);
         $display("out-of-circle normals and random quads under valid/ready gaps");
         if (mismatches == 0 && texel_fifo.size() == 0) begin
            $display("All tests passed");
         end else begin
            $display("Some tests failed");
         end
      end
      $finish;
   end

endmodule
